FILE: rtl/core/pce_pkg.sv
// Shared types and constants for the pixel color enhancement pipeline.
package pce_pkg;

    // Color channels, index 0 blue, 1 green, 2 red.
    localparam int NUM_CHAN = 3;

    typedef logic [NUM_CHAN-1:0][7:0] chan_arr_t;

    typedef struct packed {
        logic [7:0] alpha;
        chan_arr_t  color;
    } pix_t;

    // Configuration register indexes (paddr[3:2]).
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_CONTRAST   = 2'd1;
    localparam logic [1:0] REG_SATURATION = 2'd2;

    localparam logic signed [8:0] BRIGHTNESS_RESET = 9'sd0;
    localparam logic [14:0]       CONTRAST_RESET   = 15'd4096;
    localparam logic [13:0]       SATURATION_RESET = 14'd4096;

    // 127.5 * 2^13, the mid grey term of the contrast stage.
    localparam logic signed [25:0] CONTRAST_BIAS = 26'sd1044480;

    // Rec.601 luma weights in Q0.16, sum is 65536.
    localparam logic [23:0] LUMA_R = 24'd19595;
    localparam logic [23:0] LUMA_G = 24'd38470;
    localparam logic [23:0] LUMA_B = 24'd7471;

endpackage

FILE: rtl/core/pce_bright_contrast.sv
// Brightness offset and contrast gain stages (three register stages).
module pce_bright_contrast (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  pce_pkg::pix_t         in_pix,
    input  logic signed [8:0]     offset,
    input  logic [14:0]           gain,
    output logic                  out_valid,
    output pce_pkg::pix_t         out_pix
);
    import pce_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    pix_t bright_reg;
    pix_t bright_next;
    logic signed [NUM_CHAN-1:0][25:0] cnum_reg;
    logic signed [NUM_CHAN-1:0][25:0] cnum_next;
    logic [7:0] alpha2_reg;
    pix_t cont_reg;
    pix_t cont_next;

    // stage 1: add offset, clamp
    always_comb begin
        logic signed [9:0] sum;
        bright_next.alpha = in_pix.alpha;
        for (int i = 0; i < NUM_CHAN; i++) begin
            sum = $signed({2'b00, in_pix.color[i]}) + $signed({offset[8], offset});
            if (sum < 0) begin
                bright_next.color[i] = 8'd0;
            end else if (sum > 10'sd255) begin
                bright_next.color[i] = 8'd255;
            end else begin
                bright_next.color[i] = sum[7:0];
            end
        end
    end

    // stage 2: (2c - 255) * G + 255 * 4096
    always_comb begin
        logic signed [9:0] span;
        for (int i = 0; i < NUM_CHAN; i++) begin
            span = $signed({1'b0, bright_reg.color[i], 1'b0}) - 10'sd255;
            cnum_next[i] = span * $signed({1'b0, gain}) + CONTRAST_BIAS;
        end
    end

    // stage 3: divide by 2^13 toward zero, clamp
    always_comb begin
        logic [12:0] quot;
        cont_next.alpha = alpha2_reg;
        for (int i = 0; i < NUM_CHAN; i++) begin
            quot = cnum_reg[i][25:13];
            if ($signed(cnum_reg[i]) <= 0) begin
                cont_next.color[i] = 8'd0;
            end else if (quot > 13'd255) begin
                cont_next.color[i] = 8'd255;
            end else begin
                cont_next.color[i] = quot[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bright_reg <= bright_next;
            cnum_reg   <= cnum_next;
            alpha2_reg <= bright_reg.alpha;
            cont_reg   <= cont_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_pix   = cont_reg;

endmodule

FILE: rtl/core/pce_saturation.sv
// Luma and saturation stages (three register stages, last one is the output).
module pce_saturation (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  pce_pkg::pix_t in_pix,
    input  logic [13:0]   gain,
    output logic          out_valid,
    output pce_pkg::pix_t out_pix
);
    import pce_pkg::*;

    logic v4_reg, v5_reg, v6_reg;
    logic [23:0] luma_reg;
    logic [23:0] luma_next;
    pix_t chan4_reg;
    logic signed [NUM_CHAN-1:0][41:0] snum_reg;
    logic signed [NUM_CHAN-1:0][41:0] snum_next;
    logic [7:0] alpha5_reg;
    pix_t sat_reg;
    pix_t sat_next;

    // stage 4: luma in Q16
    assign luma_next = LUMA_R * {16'd0, in_pix.color[2]}
                     + LUMA_G * {16'd0, in_pix.color[1]}
                     + LUMA_B * {16'd0, in_pix.color[0]};

    // stage 5: Y * 4096 + (c * 65536 - Y) * S
    always_comb begin
        logic signed [25:0] diff;
        for (int i = 0; i < NUM_CHAN; i++) begin
            diff = $signed({2'b00, chan4_reg.color[i], 16'd0}) - $signed({2'b00, luma_reg});
            snum_next[i] = diff * $signed({2'b00, gain})
                         + $signed({6'd0, luma_reg, 12'd0});
        end
    end

    // stage 6: divide by 2^28 toward zero, clamp
    always_comb begin
        logic [13:0] quot;
        sat_next.alpha = alpha5_reg;
        for (int i = 0; i < NUM_CHAN; i++) begin
            quot = snum_reg[i][41:28];
            if ($signed(snum_reg[i]) <= 0) begin
                sat_next.color[i] = 8'd0;
            end else if (quot > 14'd255) begin
                sat_next.color[i] = 8'd255;
            end else begin
                sat_next.color[i] = quot[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            luma_reg   <= luma_next;
            chan4_reg  <= in_pix;
            snum_reg   <= snum_next;
            alpha5_reg <= chan4_reg.alpha;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_pix   = sat_reg;

endmodule

FILE: rtl/core/pixel_color_enhance.sv
// Top level: pixel brightness / contrast / saturation adjust with APB config.
// Six register stages lie between request acceptance and m_tvalid.
// Throughput: one pixel per clock; the whole pipeline advances together and
// halts only while the output register holds a request m_tready has not taken.
// Reset (aresetn low, synchronous): all stage valid bits clear, registers
// return to offset 0, contrast gain 4096, saturation gain 4096.
module pixel_color_enhance (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16], alpha_in[31:24]
    // adjusted pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pce_pkg::*;

    logic signed [8:0] brightness_reg;
    logic [14:0]       contrast_reg;
    logic [13:0]       saturation_reg;

    logic       cfg_wr;
    logic [1:0] cfg_idx;

    logic pipe_en;
    logic mid_valid;
    pix_t in_pix;
    pix_t mid_pix;
    pix_t out_pix;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHTNESS_RESET;
            contrast_reg   <= CONTRAST_RESET;
            saturation_reg <= SATURATION_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BRIGHTNESS: brightness_reg <= $signed(pwdata[8:0]);
                REG_CONTRAST:   contrast_reg   <= pwdata[14:0];
                REG_SATURATION: saturation_reg <= pwdata[13:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BRIGHTNESS: prdata = {{23{brightness_reg[8]}}, brightness_reg};
            REG_CONTRAST:   prdata = {17'd0, contrast_reg};
            REG_SATURATION: prdata = {18'd0, saturation_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Single enable for all stages: move whenever the output slot is free or
    // being drained this cycle. Bubbles ride along as cleared valid bits.
    assign pipe_en  = ~m_tvalid | m_tready;
    assign s_tready = pipe_en;

    assign in_pix.color[0] = s_tdata[7:0];
    assign in_pix.color[1] = s_tdata[15:8];
    assign in_pix.color[2] = s_tdata[23:16];
    assign in_pix.alpha    = s_tdata[31:24];

    // stages 1..3: brightness, contrast
    pce_bright_contrast u_bc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_pix    (in_pix),
        .offset    (brightness_reg),
        .gain      (contrast_reg),
        .out_valid (mid_valid),
        .out_pix   (mid_pix)
    );

    // stages 4..6: luma, saturation, output register
    pce_saturation u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (mid_valid),
        .in_pix    (mid_pix),
        .gain      (saturation_reg),
        .out_valid (m_tvalid),
        .out_pix   (out_pix)
    );

    assign m_tdata = {out_pix.alpha, out_pix.color[2], out_pix.color[1], out_pix.color[0]};

endmodule

FILE: rtl/core/pce_checker.sv
// Port-level checks for pixel_color_enhance, bound to the top level.
module pce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // input side is held only by a stalled output
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not track output stall");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind pixel_color_enhance pce_checker u_pce_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for pixel_color_enhance: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import pce_pkg::*;

    // Register index past the end of the map; the block must ignore writes to it.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int NUM_DIR     = 29;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 175;
    localparam int LONG_HOLD   = 400;  // receiver hold-off, cycles
    localparam int TAIL_CYCLES = 12;   // pipeline is 6 deep

    typedef enum logic [0:0] {ROW_WRITE, ROW_PIXEL} row_kind_t;

    // One row of the directed table. For pixel rows idx is don't-care;
    // typed says whether want holds a hand-computed result.
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [31:0] data;
        logic        typed;
        logic [31:0] want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // blue_in[7:0], green_in[15:8], red_in[23:16], alpha_in[31:24]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block's configuration.
    logic signed [8:0] bright_off;
    logic [14:0]       contrast_g;
    logic [13:0]       satur_g;

    // Expected output pixels, oldest first.
    logic [31:0] pending_pix [$];
    int          mismatch_cnt;

    // Idle percentages for each side, and the long hold-off request.
    int src_idle_pct;
    int dst_idle_pct;
    bit long_hold_req;

    dir_row_t dir_tab [0:NUM_DIR-1];

    pixel_color_enhance uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Truncate a scaled stage result and clamp it to a byte.
    function automatic logic [7:0] trunc_byte(input longint num, input int sh);
        longint q;
        if (num <= 0) return 8'd0;
        q = num >>> sh;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Brightness, contrast, then saturation around Rec.601 luma; alpha untouched.
    function automatic logic [31:0] enhance_pixel(input pix_t pin);
        pix_t      pout;
        logic [7:0] chan [3];
        longint    v;
        longint    luma;
        for (int i = 0; i < 3; i++) begin
            v = longint'(pin.color[i]) + longint'(bright_off);
            chan[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            v = (2 * longint'(chan[i]) - 255) * longint'(contrast_g) + 255 * 4096;
            chan[i] = trunc_byte(v, 13);
        end
        // luma in Q16 from the contrast stage output
        luma = 64'd19595 * chan[2] + 64'd38470 * chan[1] + 64'd7471 * chan[0];
        for (int i = 0; i < 3; i++) begin
            v = luma * 4096 + (longint'(chan[i]) * 65536 - luma) * longint'(satur_g);
            pout.color[i] = trunc_byte(v, 28);
        end
        pout.alpha = pin.alpha;
        return pout;
    endfunction

    // APB write: setup cycle, access cycle, shadow copy update, then an idle cycle.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bits past each register's width are dropped
        case (idx)
            REG_BRIGHTNESS: bright_off = val[8:0];
            REG_CONTRAST:   contrast_g = val[14:0];
            REG_SATURATION: satur_g    = val[13:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Offer one request, with a random gap first; log the expectation on accept.
    task automatic send_pixel(input logic [31:0] pix, input logic typed,
                              input logic [31:0] want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        pending_pix = {pending_pix, (typed ? want : enhance_pixel(pix))};
    endtask

    // Stop offering and wait until every expected pixel has come back.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge aclk);
    endtask

    // Receiver: checks each accepted request at the edge, then picks the next m_tready.
    initial begin
        string       fld [4];
        int          hold_left;
        logic [31:0] want;
        fld = '{"blue_out", "green_out", "red_out", "alpha_out"};
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (pending_pix.size() == 0) begin
                    $error("unexpected output pixel %h", m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = pending_pix.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (m_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                            $error("%s expected %0d got %0d", fld[i],
                                   want[8*i +: 8], m_tdata[8*i +: 8]);
                            mismatch_cnt++;
                        end
                    end
                end
            end
            // long hold-off counted here, while the sender keeps pushing
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Main sequence: reset, directed table, random phases, final verdict.
    initial begin
        logic [31:0] pix;
        logic [31:0] bval;
        logic [31:0] cval;
        logic [31:0] sval;

        // row: kind, reg index, register value or pixel, typed, expected pixel
        dir_tab = '{
            // reset config is identity
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h807F_01FE, 1'b1, 32'h807F_01FE},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h55AA_33CC, 1'b1, 32'h55AA_33CC},
            // full positive offset saturates every channel
            '{ROW_WRITE, REG_BRIGHTNESS, 32'h0000_00FF, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h1200_4080, 1'b1, 32'h12FF_FFFF},
            // full negative offset, upper bits set and ignored
            '{ROW_WRITE, REG_BRIGHTNESS, 32'hFFFF_FF01, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'hABFF_FFFF, 1'b1, 32'hAB00_0000},
            '{ROW_WRITE, REG_BRIGHTNESS, 32'hFFFF_FF80, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h01FF_80C0, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'hFE7F_0000, 1'b0, 32'h0},
            // zero contrast flattens to mid grey
            '{ROW_WRITE, REG_CONTRAST,   32'h0000_0000, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'hA512_3456, 1'b1, 32'hA57F_7F7F},
            // contrast gain above range: negative stage results clamp to zero
            '{ROW_WRITE, REG_CONTRAST,   32'h0000_7FFF, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h00FF_0080, 1'b0, 32'h0},
            '{ROW_WRITE, REG_BRIGHTNESS, 32'h0000_0000, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h10C0_8040, 1'b0, 32'h0},
            // zero saturation gives grey at luma
            '{ROW_WRITE, REG_CONTRAST,   32'h0000_1000, 1'b0, 32'h0},
            '{ROW_WRITE, REG_SATURATION, 32'h0000_0000, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h7F20_4060, 1'b0, 32'h0},
            // saturation above range and past width
            '{ROW_WRITE, REG_SATURATION, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h3380_8070, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h00FF_00FF, 1'b0, 32'h0},
            // write to an unmapped index must change nothing
            '{ROW_WRITE, REG_UNUSED,     32'h0000_0001, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h4440_5060, 1'b0, 32'h0},
            // top of the stated gain ranges
            '{ROW_WRITE, REG_CONTRAST,   32'h0000_4000, 1'b0, 32'h0},
            '{ROW_WRITE, REG_SATURATION, 32'h0000_2000, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'h9980_7060, 1'b0, 32'h0},
            '{ROW_PIXEL, REG_BRIGHTNESS, 32'hFFFF_FFFF, 1'b0, 32'h0}
        };

        mismatch_cnt  = 0;
        long_hold_req = 1'b0;
        src_idle_pct  = 13;
        dst_idle_pct  = 59;
        bright_off    = BRIGHTNESS_RESET;
        contrast_g    = CONTRAST_RESET;
        satur_g       = SATURATION_RESET;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; writes only once the pipe is empty
        for (int r = 0; r < NUM_DIR; r++) begin
            if (dir_tab[r].kind == ROW_WRITE) begin
                drain_pipe();
                reg_write(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                send_pixel(dir_tab[r].data, dir_tab[r].typed, dir_tab[r].want);
            end
        end

        // random phases: new settings each phase, idling profile per third
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipe();
            case ($urandom_range(5))
                0:       bval = 32'h0000_00FF;
                1:       bval = 32'hFFFF_FF01;
                2:       bval = $urandom();
                default: bval = $urandom_range(511);
            endcase
            case ($urandom_range(6))
                0:       cval = 32'h0000_0000;
                1:       cval = 32'h0000_4000;
                2:       cval = 32'h0000_1000;
                3:       cval = $urandom();
                default: cval = $urandom_range(16384);
            endcase
            case ($urandom_range(6))
                0:       sval = 32'h0000_0000;
                1:       sval = 32'h0000_2000;
                2:       sval = 32'h0000_1000;
                3:       sval = $urandom();
                default: sval = $urandom_range(8192);
            endcase
            reg_write(REG_BRIGHTNESS, bval);
            reg_write(REG_CONTRAST, cval);
            reg_write(REG_SATURATION, sval);

            if (ph < 3) begin
                src_idle_pct = 13;
                dst_idle_pct = 59;
            end else if (ph < 6) begin
                src_idle_pct = 59;
                dst_idle_pct = 13;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            // back-pressure until the input side stalls
            if (ph == 1) long_hold_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pix = $urandom();
                if ($urandom_range(3) == 0) begin
                    for (int c = 0; c < 4; c++) begin
                        case ($urandom_range(2))
                            0:       pix[8*c +: 8] = 8'h00;
                            1:       pix[8*c +: 8] = 8'hFF;
                            default: pix[8*c +: 8] = $urandom_range(255);
                        endcase
                    end
                end
                send_pixel(pix, 1'b0, 32'h0);
            end
        end

        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
